>>> sv/dtpc_pkg.sv
`default_nettype none

package dtpc_pkg;

  // position format
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 20;
  // dividend of the dead reckoning division: elapsed time scaled by full travel
  localparam int DIV_W     = TIME_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [POS_W-1:0] FULL_POS = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_LOW  = POS_W'((1 << FRAC_BITS) / 100);
  localparam logic [POS_W-1:0] POS_HIGH = POS_W'(((1 << FRAC_BITS) * 99) / 100);
  localparam logic [POS_W-1:0] POS_HALF = POS_W'(1) << (FRAC_BITS - 1);

  // motion codes
  localparam logic [1:0] MOT_IDLE  = 2'd0;
  localparam logic [1:0] MOT_OPEN  = 2'd1;
  localparam logic [1:0] MOT_CLOSE = 2'd2;

  // action codes
  localparam logic [2:0] ACT_RX     = 3'd0;
  localparam logic [2:0] ACT_TICK   = 3'd1;
  localparam logic [2:0] ACT_STOP   = 3'd2;
  localparam logic [2:0] ACT_TOGGLE = 3'd3;
  localparam logic [2:0] ACT_GOTO   = 3'd4;

  // bytes sent on the line
  localparam logic [7:0] BYTE_QUERY = 8'h38;
  localparam logic [7:0] BYTE_PRESS = 8'h30;

  // status byte codes from the opener
  localparam logic [7:0] ST_CLOSED_A  = 8'hB5;
  localparam logic [7:0] ST_CLOSED_B  = 8'hF5;
  localparam logic [7:0] ST_CLOSED_C  = 8'h55;
  localparam logic [7:0] ST_OPENED    = 8'h52;
  localparam logic [7:0] ST_OPENING_A = 8'h51;
  localparam logic [7:0] ST_OPENING_B = 8'h01;
  localparam logic [7:0] ST_OPENING_C = 8'h11;
  localparam logic [7:0] ST_CLOSING_A = 8'h44;
  localparam logic [7:0] ST_CLOSING_B = 8'h14;
  localparam logic [7:0] ST_STOP_UP_A = 8'h86;
  localparam logic [7:0] ST_STOP_UP_B = 8'h16;
  localparam logic [7:0] ST_STOP_UP_C = 8'h06;
  localparam logic [7:0] ST_STOP_DN_A = 8'h10;
  localparam logic [7:0] ST_STOP_DN_B = 8'h00;

  // register indexes
  localparam logic REG_OPEN_TIME  = 1'b0;
  localparam logic REG_CLOSE_TIME = 1'b1;

  localparam logic [CFG_W-1:0] TRAVEL_RESET = CFG_W'(15000);

  typedef struct packed {
    logic [2:0]        action;
    logic [7:0]        rx_byte;
    logic [POS_W-1:0]  goal_position;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic [POS_W-1:0] door_position;
    logic [1:0]       motion;
    logic [7:0]       presses_pending;
  } out_word_t;

  // request into the divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

>>> sv/dtpc_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module dtpc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dtpc_pkg::div_req_t        req,
  output logic                           done,
  output logic [dtpc_pkg::DIV_W-1:0]     quotient
);

  logic [dtpc_pkg::CFG_W-1:0]     divisor;
  logic [dtpc_pkg::CFG_W-1:0]     rem;
  logic [dtpc_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic [dtpc_pkg::CFG_W:0]       rem_shift;
  logic [dtpc_pkg::CFG_W:0]       rem_diff;
  logic                           fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_shift = {rem, quotient[dtpc_pkg::DIV_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = rem_shift >= {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + dtpc_pkg::DIV_CNT_W'(1);
        if (cnt == dtpc_pkg::DIV_CNT_W'(dtpc_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= rem_diff[dtpc_pkg::CFG_W-1:0];
        quotient <= {quotient[dtpc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[dtpc_pkg::CFG_W-1:0];
        quotient <= {quotient[dtpc_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/door_toggle_position_controller.sv
`default_nettype none

// channel  | handshake                  | word
// ---------+----------------------------+---------------------------------------
// in       | in_valid / in_ready        | in_data: action, rx_byte, goal, now_ms
// out      | out_valid / out_ready      | out_data: tx, position, motion, presses
// cfg      | cfg_we (no wait)           | cfg_index, cfg_data (travel times)
//
// one word at a time: in_ready is high only while the sequencer waits for a word
// status bytes and commands go from S_EXEC straight to S_EMIT, where the result is made valid
// a tick with no dead reckoning to do goes through S_EXEC, S_CHECK and S_EMIT
// a moving tick with a later stamp also waits in S_DIV for the divider quotient before S_CHECK
// an unread result in the output register holds the next one back in its last step
// rst is synchronous; after it both travel times are 15000 ms, position is half open
module door_toggle_position_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire dtpc_pkg::in_word_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dtpc_pkg::out_word_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [dtpc_pkg::CFG_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_CHECK,
    S_EMIT
  } state_t;

  localparam int DC_W = dtpc_pkg::POS_W + 1;

  state_t                            state;
  dtpc_pkg::in_word_t                item;
  logic [dtpc_pkg::CFG_W-1:0]        open_time;
  logic [dtpc_pkg::CFG_W-1:0]        close_time;
  logic                              echo_seen;
  logic [1:0]                        cur_motion;
  logic [1:0]                        next_dir;
  logic [1:0]                        cmd_motion;
  logic [7:0]                        press_count;
  logic [1:0]                        tick_phase;
  logic [dtpc_pkg::POS_W-1:0]        position;
  logic [dtpc_pkg::POS_W-1:0]        target;
  logic [dtpc_pkg::TIME_W-1:0]       last_ms;
  logic                              tx_valid;
  logic [7:0]                        tx_byte;

  dtpc_pkg::div_req_t                div_req;
  logic                              div_done;
  logic [dtpc_pkg::DIV_W-1:0]        div_quo;

  logic [dtpc_pkg::CFG_W-1:0]        travel;
  logic                              moving;
  logic [dtpc_pkg::POS_W-1:0]        goal_sat;
  logic [DC_W-1:0]                   delta;
  logic [DC_W:0]                     pos_sum;
  logic [DC_W:0]                     pos_new;
  logic [dtpc_pkg::POS_W-1:0]        pos_clamped;
  logic                              reached;

  // presses needed to reach a commanded direction
  function automatic logic [7:0] press_need(input logic [1:0] dir, input logic [1:0] cur,
                                            input logic [1:0] nxt);
    logic [7:0] n;
    if (dir == nxt) begin
      n = 8'd1;
    end else if (cur == dtpc_pkg::MOT_IDLE) begin
      n = 8'd3;
    end else begin
      n = 8'd2;
    end
    return n;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign moving   = (cur_motion == dtpc_pkg::MOT_OPEN) || (cur_motion == dtpc_pkg::MOT_CLOSE);

  // divider request for dead reckoning
  always_comb begin
    travel = (cur_motion == dtpc_pkg::MOT_OPEN) ? open_time : close_time;
    if (travel == '0) begin
      travel = dtpc_pkg::CFG_W'(1);
    end
    div_req.start    = (state == S_EXEC) && (item.action == dtpc_pkg::ACT_TICK) && moving &&
                       (item.now_ms > last_ms);
    div_req.dividend = {item.now_ms - last_ms, {dtpc_pkg::FRAC_BITS{1'b0}}};
    div_req.divisor  = travel;
  end

  dtpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // new position from the quotient, clamped to the travel window
  always_comb begin
    if (|div_quo[dtpc_pkg::DIV_W-1:DC_W]) begin
      delta = '1;
    end else begin
      delta = div_quo[DC_W-1:0];
    end
    pos_sum = (DC_W + 1)'(position) + (DC_W + 1)'(delta);
    if (cur_motion == dtpc_pkg::MOT_OPEN) begin
      pos_new = pos_sum;
    end else if ((DC_W + 1)'(position) < (DC_W + 1)'(delta)) begin
      pos_new = '0;
    end else begin
      pos_new = (DC_W + 1)'(position) - (DC_W + 1)'(delta);
    end
    if (pos_new < (DC_W + 1)'(dtpc_pkg::POS_LOW)) begin
      pos_clamped = dtpc_pkg::POS_LOW;
    end else if (pos_new > (DC_W + 1)'(dtpc_pkg::POS_HIGH)) begin
      pos_clamped = dtpc_pkg::POS_HIGH;
    end else begin
      pos_clamped = pos_new[dtpc_pkg::POS_W-1:0];
    end
  end

  // intermediate target test
  always_comb begin
    goal_sat = (item.goal_position > dtpc_pkg::FULL_POS) ? dtpc_pkg::FULL_POS
                                                          : item.goal_position;
    if ((target == dtpc_pkg::FULL_POS) || (target == '0)) begin
      reached = 1'b0;
    end else if (cmd_motion == dtpc_pkg::MOT_OPEN) begin
      reached = position >= target;
    end else if (cmd_motion == dtpc_pkg::MOT_CLOSE) begin
      reached = position <= target;
    end else if (cmd_motion == dtpc_pkg::MOT_IDLE) begin
      reached = cur_motion == dtpc_pkg::MOT_IDLE;
    end else begin
      reached = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_time  <= dtpc_pkg::TRAVEL_RESET;
      close_time <= dtpc_pkg::TRAVEL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtpc_pkg::REG_OPEN_TIME:  open_time  <= cfg_data;
        dtpc_pkg::REG_CLOSE_TIME: close_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      echo_seen   <= 1'b0;
      cur_motion  <= dtpc_pkg::MOT_IDLE;
      next_dir    <= dtpc_pkg::MOT_IDLE;
      cmd_motion  <= dtpc_pkg::MOT_IDLE;
      press_count <= '0;
      tick_phase  <= '0;
      position    <= dtpc_pkg::POS_HALF;
      target      <= '0;
      last_ms     <= '0;
      tx_valid    <= 1'b0;
      tx_byte     <= '0;
      out_valid   <= 1'b0;
    end else begin
      // result valid: set as a word is emitted, cleared when taken
      if ((state == S_EMIT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          tx_valid <= (item.action == dtpc_pkg::ACT_TICK);
          if (item.action != dtpc_pkg::ACT_TICK) begin
            tx_byte <= '0;
            state   <= S_EMIT;
          end
          unique case (item.action)
            dtpc_pkg::ACT_RX: begin
              if (!echo_seen) begin
                echo_seen <= (item.rx_byte == dtpc_pkg::BYTE_QUERY);
              end else begin
                unique case (item.rx_byte)
                  dtpc_pkg::ST_CLOSED_A, dtpc_pkg::ST_CLOSED_B,
                  dtpc_pkg::ST_CLOSED_C: begin
                    next_dir   <= dtpc_pkg::MOT_OPEN;
                    cur_motion <= dtpc_pkg::MOT_IDLE;
                    position   <= '0;
                  end
                  dtpc_pkg::ST_OPENED: begin
                    next_dir   <= dtpc_pkg::MOT_CLOSE;
                    cur_motion <= dtpc_pkg::MOT_IDLE;
                    position   <= dtpc_pkg::FULL_POS;
                  end
                  dtpc_pkg::ST_OPENING_A, dtpc_pkg::ST_OPENING_B,
                  dtpc_pkg::ST_OPENING_C: begin
                    next_dir <= dtpc_pkg::MOT_IDLE;
                    if (cur_motion != dtpc_pkg::MOT_OPEN) begin
                      cur_motion <= dtpc_pkg::MOT_OPEN;
                      last_ms    <= item.now_ms;
                    end
                  end
                  dtpc_pkg::ST_CLOSING_A, dtpc_pkg::ST_CLOSING_B: begin
                    next_dir <= dtpc_pkg::MOT_IDLE;
                    if (cur_motion != dtpc_pkg::MOT_CLOSE) begin
                      cur_motion <= dtpc_pkg::MOT_CLOSE;
                      last_ms    <= item.now_ms;
                    end
                  end
                  dtpc_pkg::ST_STOP_UP_A, dtpc_pkg::ST_STOP_UP_B,
                  dtpc_pkg::ST_STOP_UP_C: begin
                    next_dir   <= dtpc_pkg::MOT_CLOSE;
                    cur_motion <= dtpc_pkg::MOT_IDLE;
                  end
                  dtpc_pkg::ST_STOP_DN_A, dtpc_pkg::ST_STOP_DN_B: begin
                    next_dir   <= dtpc_pkg::MOT_OPEN;
                    cur_motion <= dtpc_pkg::MOT_IDLE;
                  end
                  default: ;
                endcase
              end
            end

            dtpc_pkg::ACT_TICK: begin
              if (press_count != '0) begin
                if (tick_phase == '0) begin
                  press_count <= press_count - 8'd1;
                  tx_byte     <= dtpc_pkg::BYTE_PRESS;
                end else begin
                  tx_byte <= dtpc_pkg::BYTE_QUERY;
                end
                tick_phase <= tick_phase + 2'd1;
              end else begin
                tx_byte    <= dtpc_pkg::BYTE_QUERY;
                tick_phase <= '0;
              end
              if (div_req.start) begin
                state <= S_DIV;
              end else begin
                state <= S_CHECK;
              end
            end

            dtpc_pkg::ACT_STOP: begin
              cmd_motion <= dtpc_pkg::MOT_IDLE;
              if (cur_motion != dtpc_pkg::MOT_IDLE) begin
                press_count <= press_need(dtpc_pkg::MOT_IDLE, cur_motion, next_dir);
              end
            end

            dtpc_pkg::ACT_TOGGLE: begin
              if (cmd_motion != dtpc_pkg::MOT_IDLE) begin
                cmd_motion <= dtpc_pkg::MOT_IDLE;
                if (cur_motion != dtpc_pkg::MOT_IDLE) begin
                  press_count <= press_need(dtpc_pkg::MOT_IDLE, cur_motion, next_dir);
                end
              end else if (press_count != 8'hFF) begin
                press_count <= press_count + 8'd1;
              end
            end

            dtpc_pkg::ACT_GOTO: begin
              if (goal_sat == position) begin
                cmd_motion <= dtpc_pkg::MOT_IDLE;
                if (cur_motion != dtpc_pkg::MOT_IDLE) begin
                  press_count <= press_need(dtpc_pkg::MOT_IDLE, cur_motion, next_dir);
                end
              end else if (goal_sat < position) begin
                target     <= goal_sat;
                cmd_motion <= dtpc_pkg::MOT_CLOSE;
                if (cur_motion != dtpc_pkg::MOT_CLOSE) begin
                  press_count <= press_need(dtpc_pkg::MOT_CLOSE, cur_motion, next_dir);
                end
              end else begin
                target     <= goal_sat;
                cmd_motion <= dtpc_pkg::MOT_OPEN;
                if (cur_motion != dtpc_pkg::MOT_OPEN) begin
                  press_count <= press_need(dtpc_pkg::MOT_OPEN, cur_motion, next_dir);
                end
              end
            end

            default: ;
          endcase
        end

        // wait for the dead reckoning quotient
        S_DIV: begin
          if (div_done) begin
            position <= pos_clamped;
            last_ms  <= item.now_ms;
            state    <= S_CHECK;
          end
        end

        // stop at an intermediate target
        S_CHECK: begin
          if ((cur_motion != dtpc_pkg::MOT_IDLE) && (cmd_motion != dtpc_pkg::MOT_IDLE) &&
              reached) begin
            cmd_motion  <= dtpc_pkg::MOT_IDLE;
            press_count <= press_need(dtpc_pkg::MOT_IDLE, cur_motion, next_dir);
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result word, loaded when the output register frees up
  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!out_valid || out_ready)) begin
      out_data.tx_valid        <= tx_valid;
      out_data.tx_byte         <= tx_byte;
      out_data.door_position   <= position;
      out_data.motion          <= cur_motion;
      out_data.presses_pending <= press_count;
    end
  end

endmodule

`default_nettype wire

>>> sv/dtpc_checker.sv
`default_nettype none

module dtpc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire dtpc_pkg::out_word_t        out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in work");

  // only query or press bytes go out, and nothing when no byte is sent
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.tx_valid && (out_data.tx_byte == dtpc_pkg::BYTE_QUERY ||
                   out_data.tx_byte == dtpc_pkg::BYTE_PRESS)) ||
                  (!out_data.tx_valid && out_data.tx_byte == 8'h00))
    else $error("bad transmit byte");

  // position within travel and a known motion code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.door_position <= dtpc_pkg::FULL_POS &&
                  out_data.motion != 2'd3)
    else $error("bad position or motion");

endmodule

bind door_toggle_position_controller dtpc_checker u_dtpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
